// ===== rtl/ttdp_pkg.sv =====
// Shared types, codes and the quarter-wave sine table for the tone table player.
// Used by tone_table_dds_pwm_player; depends on nothing else.
`timescale 1ns / 1ps

package ttdp_pkg;

  localparam int EVENT_COUNT = 64;

  // APB register map: register i at byte address 4*i
  localparam int          ADDR_W             = 4;
  localparam logic [1:0]  REG_PWM_PERIOD     = 2'd0;
  localparam logic [1:0]  REG_REPEAT_GAP     = 2'd1;
  localparam logic [1:0]  REG_PLAY_COUNT     = 2'd2;

  localparam logic [15:0] PWM_PERIOD_RST     = 16'd2;
  localparam logic [31:0] REPEAT_GAP_RST     = 32'd0;
  localparam logic [7:0]  PLAY_COUNT_RST     = 8'd1;

  // request operation codes
  localparam logic [1:0]  OP_LOAD            = 2'd0;
  localparam logic [1:0]  OP_START           = 2'd1;
  localparam logic [1:0]  OP_TICK            = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  entry_index;
    logic        entry_tone;
    logic [31:0] entry_phase_step;
    logic [31:0] entry_samples;
  } req_t;

  typedef struct packed {
    logic [15:0] low_side_compare;
    logic [15:0] high_side_compare;
    logic        done_res;
  } rsp_t;

  // round(32767*sin(pi*i/128)), i = 0..64
  localparam logic [14:0] QUARTER_SINE [65] = '{
    15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
    15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
    15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
    15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
    15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
    15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
    15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
    15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
    15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
    15'd32757, 15'd32767
  };

endpackage

// ===== rtl/tone_table_dds_pwm_player.sv =====
// Tone table player: event table, DDS phase accumulator, sine lookup, PWM compare pair.
// Depends on ttdp_pkg.
//
// Usage:
//   Requests arrive on req (valid/ready). A load writes one event table slot, a start
//   rewinds to event 0 with play_count passes, a tick advances the player by one carrier
//   period and yields one compare pair on rsp (valid/ready). Loads and starts yield
//   nothing. Configuration is written over the APB port while the block is idle.
//   A tick's result is registered and is on rsp in the cycle after the tick is taken.
//   Throughput: one tick per cycle while the player stays inside an event or a gap and rsp does not stall.
//   A start, a move to the next event and a restart of the table are each followed by a
//   fetch cycle in which req_ready is low: the event table is a synchronous RAM and the
//   entries for the new position arrive from it in that cycle. With one-tick events, a
//   fetch therefore follows every tick.
//   The result register frees itself when rsp_ready is high in the same cycle, so
//   ticks keep flowing while results are taken each cycle. When rsp stalls, ticks wait;
//   loads and starts are still taken.
//   Reset (synchronous, rst high) leaves the player finished with zero passes, the
//   registers at their defaults and no result pending. Table contents are not cleared.
`timescale 1ns / 1ps

module tone_table_dds_pwm_player #(
  parameter int EVENT_COUNT = ttdp_pkg::EVENT_COUNT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  ttdp_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output ttdp_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ttdp_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int PW = $clog2(EVENT_COUNT + 1);
  localparam int AW = (EVENT_COUNT > 1) ? $clog2(EVENT_COUNT) : 1;

  // configuration
  logic [15:0] pwm_period;
  logic [31:0] repeat_gap_samples;
  logic [7:0]  play_count;

  // player state
  logic [PW-1:0] pos, pos_next;
  logic [31:0]   phase, phase_next;
  logic [31:0]   ticks, ticks_next;
  logic [31:0]   gap, gap_next;
  logic [7:0]    passes, passes_next;
  logic          fetch, fetch_next;

  // copies of the entries in use
  logic        cur_tone;
  logic [31:0] cur_step;
  logic [31:0] nxt_len;
  logic [31:0] len0;

  // event table RAMs
  logic [32:0] ts_mem  [EVENT_COUNT];
  logic [31:0] len_mem [EVENT_COUNT];
  logic [32:0] ts_rd;
  logic [31:0] len_rd;
  logic [PW:0] len_addr;

  logic        take, is_load, is_start, is_tick, slot_ok, finished;
  logic [7:0]  slot8, pos8;
  logic [PW-1:0] pos_inc;
  logic [31:0] ticks_dec;
  logic        sounding;

  // sine and pulse
  logic [7:0]  sidx;
  logic [6:0]  qaddr;
  logic [14:0] mag;
  logic [30:0] prod;
  logic [15:0] pulse;
  logic [15:0] low_cmp, high_cmp;

  assign req_ready = !fetch &&
                     (!rsp_valid || rsp_ready || req.operation != ttdp_pkg::OP_TICK);
  assign take      = req_valid && req_ready;
  assign is_load   = take && req.operation == ttdp_pkg::OP_LOAD;
  assign is_start  = take && req.operation == ttdp_pkg::OP_START;
  assign is_tick   = take && req.operation == ttdp_pkg::OP_TICK;
  assign slot_ok   = {26'd0, req.entry_index} < 32'(EVENT_COUNT);
  assign slot8     = {2'b00, req.entry_index};
  assign pos8      = 8'(pos);
  assign finished  = pos >= PW'(EVENT_COUNT);
  assign pos_inc   = pos + PW'(1);
  assign ticks_dec = ticks - 32'd1;

  // ---------------- APB ----------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      ttdp_pkg::REG_PWM_PERIOD: prdata = {16'd0, pwm_period};
      ttdp_pkg::REG_REPEAT_GAP: prdata = repeat_gap_samples;
      ttdp_pkg::REG_PLAY_COUNT: prdata = {24'd0, play_count};
      default:                  prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period         <= ttdp_pkg::PWM_PERIOD_RST;
      repeat_gap_samples <= ttdp_pkg::REPEAT_GAP_RST;
      play_count         <= ttdp_pkg::PLAY_COUNT_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        ttdp_pkg::REG_PWM_PERIOD: pwm_period         <= pwdata[15:0];
        ttdp_pkg::REG_REPEAT_GAP: repeat_gap_samples <= pwdata;
        ttdp_pkg::REG_PLAY_COUNT: play_count         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // ---------------- sine lookup and pulse ----------------
  assign sidx     = phase[31:24];
  assign qaddr    = sidx[6] ? (7'd64 - {1'b0, sidx[5:0]}) : {1'b0, sidx[5:0]};
  assign mag      = ttdp_pkg::QUARTER_SINE[qaddr];
  assign prod     = 31'(mag) * 31'(pwm_period);
  assign pulse    = prod[30:15];
  assign sounding = (gap == 32'd0) && !finished && cur_tone;

  always_comb begin
    low_cmp  = pwm_period;
    high_cmp = pwm_period;
    if (sounding) begin
      // negative half of the wave comes off the low side
      if (sidx[7]) begin
        low_cmp  = pwm_period - pulse;
      end else begin
        high_cmp = pwm_period - pulse;
      end
    end
  end

  // ---------------- sequencing ----------------
  always_comb begin
    pos_next    = pos;
    phase_next  = phase;
    ticks_next  = ticks;
    gap_next    = gap;
    passes_next = passes;
    fetch_next  = 1'b0;
    if (is_start) begin
      pos_next    = '0;
      phase_next  = 32'd0;
      passes_next = play_count;
      ticks_next  = len0;
      gap_next    = 32'd0;
      fetch_next  = 1'b1;
    end else if (is_tick) begin
      if (gap != 32'd0) begin
        gap_next = gap - 32'd1;
      end else if (finished) begin
        if (passes > 8'd1) begin
          passes_next = passes - 8'd1;
          pos_next    = '0;
          phase_next  = 32'd0;
          ticks_next  = len0;
          gap_next    = repeat_gap_samples - 32'd1;
          fetch_next  = 1'b1;
        end
      end else begin
        if (cur_tone) begin
          phase_next = phase + cur_step;
        end
        ticks_next = ticks_dec;
        if (ticks_dec == 32'd0) begin
          pos_next   = pos_inc;
          fetch_next = 1'b1;
          if (pos_inc < PW'(EVENT_COUNT)) begin
            ticks_next = nxt_len;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= PW'(EVENT_COUNT);
      phase  <= 32'd0;
      ticks  <= 32'd0;
      gap    <= 32'd0;
      passes <= 8'd0;
      fetch  <= 1'b0;
    end else begin
      pos    <= pos_next;
      phase  <= phase_next;
      ticks  <= ticks_next;
      gap    <= gap_next;
      passes <= passes_next;
      fetch  <= fetch_next;
    end
  end

  // ---------------- event table ----------------
  // read at the position being entered (lengths at the one after it); data lands for the fetch cycle
  assign len_addr = {1'b0, pos_next} + (PW + 1)'(1);

  always_ff @(posedge clk) begin
    if (is_load && slot_ok) begin
      ts_mem[AW'(req.entry_index)]  <= {req.entry_tone, req.entry_phase_step};
      len_mem[AW'(req.entry_index)] <= req.entry_samples;
    end
    if (pos_next < PW'(EVENT_COUNT)) begin
      ts_rd <= ts_mem[AW'(pos_next)];
    end
    if (len_addr < (PW + 1)'(EVENT_COUNT)) begin
      len_rd <= len_mem[AW'(len_addr)];
    end
  end

  // working copies, kept in step with loads that hit them
  always_ff @(posedge clk) begin
    if (fetch) begin
      cur_tone <= ts_rd[32];
      cur_step <= ts_rd[31:0];
      nxt_len  <= len_rd;
    end else if (is_load && slot_ok) begin
      if (slot8 == pos8) begin
        cur_tone <= req.entry_tone;
        cur_step <= req.entry_phase_step;
      end
      if (slot8 == pos8 + 8'd1) begin
        nxt_len <= req.entry_samples;
      end
    end
    if (is_load && slot_ok && req.entry_index == 6'd0) begin
      len0 <= req.entry_samples;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (is_tick) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      rsp.low_side_compare  <= low_cmp;
      rsp.high_side_compare <= high_cmp;
      rsp.done_res          <= (pos_next >= PW'(EVENT_COUNT)) && (passes_next <= 8'd1);
    end
  end

  // ---------------- checks ----------------
  a_fetch_blocks: assert property (@(posedge clk) disable iff (rst)
    fetch |-> !req_ready)
    else $error("request taken during table fetch");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(EVENT_COUNT))
    else $error("event position beyond table");

  a_start_rewinds: assert property (@(posedge clk) disable iff (rst)
    is_start |=> fetch && pos == '0 && gap == 32'd0)
    else $error("start did not rewind the player");

  a_gap_silent: assert property (@(posedge clk) disable iff (rst)
    is_tick && gap != 32'd0 |=>
      rsp_valid && rsp.low_side_compare == rsp.high_side_compare)
    else $error("output not silent during repeat gap");

  a_passes_fall: assert property (@(posedge clk) disable iff (rst)
    !is_start |=> passes <= $past(passes))
    else $error("pass count grew without a start");

endmodule
